[hdl/rgb_dominant_color_vote_macros.svh]
// Assertion helpers, clocked on clk and quiet while arst_n is low.
`ifndef RGB_DOMINANT_COLOR_VOTE_MACROS_SVH
`define RGB_DOMINANT_COLOR_VOTE_MACROS_SVH

// same-cycle implication
`define RGBDCV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RGBDCV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/rgbdcv_pkg.sv]
package rgbdcv_pkg;

	localparam int unsigned RAW_W  = 16;
	localparam int unsigned NORM_W = 12;
	localparam int unsigned CNT_W  = 4;
	localparam int unsigned NCLS   = 4;

	localparam logic [CNT_W-1:0]  WINDOW   = 4'd10;
	localparam logic [CNT_W-1:0]  CNT_MAX  = 4'd15;
	localparam logic [NORM_W-1:0] NORM_MAX = 12'd4095;

	typedef enum logic [1:0] {
		CLS_OTHER = 2'd0,
		CLS_RED   = 2'd1,
		CLS_GREEN = 2'd2,
		CLS_BLUE  = 2'd3
	} cls_t;

	typedef struct packed {
		logic [RAW_W-1:0] red_raw;
		logic [RAW_W-1:0] green_raw;
		logic [RAW_W-1:0] blue_raw;
		logic [RAW_W-1:0] clear_raw;
	} sample_t;

	typedef struct packed {
		logic [NORM_W-1:0] red_norm;
		logic [NORM_W-1:0] green_norm;
		logic [NORM_W-1:0] blue_norm;
		logic [1:0]        sample_class;
		logic              vote_valid;
		logic [1:0]        vote_class;
	} result_t;

endpackage

[hdl/rgb_dominant_color_vote.sv]
// A sample word passes accept, 3 x 13 shared divider steps and classify/vote in turn;
// no new word is taken until its result is registered, and a stalled output word holds
// the block and blocks the input.
// A finished result waits in the output register while the next word is taken.
// Reset (arst_n low, asynchronous) empties the output and clears window position
// and class counts.
`include "rgb_dominant_color_vote_macros.svh"

module rgb_dominant_color_vote (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_stall,
	input  rgbdcv_pkg::sample_t sample,
	output logic                result_valid,
	input  logic                result_stall,
	output rgbdcv_pkg::result_t result
);
	import rgbdcv_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_FIN
	} state_t;

	localparam int unsigned REM_W = RAW_W + 8;
	localparam int unsigned DIV_W = RAW_W + NORM_W;
	localparam int unsigned QUO_W = NORM_W + 1;
	localparam logic [3:0]  STEP_FIRST = 4'(NORM_W);

	state_t             state_q;
	sample_t            smp_q;
	logic [1:0]         ch_q;
	logic [3:0]         step_q;
	logic [REM_W-1:0]   rem_q;
	logic [DIV_W-1:0]   div_q;
	logic [QUO_W-1:0]   quo_q;
	logic [NORM_W-1:0]  norm_q [3];
	logic [CNT_W-1:0]   pos_q;
	logic [CNT_W-1:0]   cnt_q [NCLS];
	result_t            result_q;
	logic               result_valid_q;

	logic               ge;
	logic [QUO_W-1:0]   quo_nxt;
	logic [NORM_W-1:0]  norm_nxt;
	logic [RAW_W-1:0]   chan_nxt;
	cls_t               cls;
	logic [CNT_W-1:0]   cnt_upd [NCLS];
	logic [CNT_W-1:0]   pos_inc;
	logic               win_done;
	logic [1:0]         vote;
	logic [CNT_W-1:0]   best;
	logic               out_free;

	// shared divider step
	assign ge       = {{(DIV_W-REM_W){1'b0}}, rem_q} >= div_q;
	assign quo_nxt  = {quo_q[QUO_W-2:0], ge};
	assign norm_nxt = quo_nxt[QUO_W-1] ? NORM_MAX : quo_nxt[NORM_W-1:0];
	assign chan_nxt = (ch_q == 2'd0) ? smp_q.green_raw : smp_q.blue_raw;

	always_comb begin
		if (norm_q[0] > norm_q[1] && norm_q[0] > norm_q[2]) begin
			cls = CLS_RED;
		end else if (norm_q[1] > norm_q[0] && norm_q[1] > norm_q[2]) begin
			cls = CLS_GREEN;
		end else if (norm_q[2] > norm_q[0] && norm_q[2] > norm_q[1]) begin
			cls = CLS_BLUE;
		end else begin
			cls = CLS_OTHER;
		end
	end

	always_comb begin
		best = '0;
		vote = CLS_OTHER;
		for (int j = 0; j < NCLS; j++) begin
			cnt_upd[j] = cnt_q[j];
			if (2'(j) == cls && cnt_q[j] != CNT_MAX) begin
				cnt_upd[j] = cnt_q[j] + 4'd1;
			end
			if (cnt_upd[j] > best) begin
				best = cnt_upd[j];
				vote = 2'(j);
			end
		end
	end

	assign pos_inc  = pos_q + 4'd1;
	assign win_done = (pos_inc >= WINDOW) || (pos_inc == '0);
	assign out_free = !result_valid_q || !result_stall;

	assign sample_stall = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			smp_q          <= '0;
			ch_q           <= '0;
			step_q         <= '0;
			rem_q          <= '0;
			div_q          <= '0;
			quo_q          <= '0;
			pos_q          <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
			for (int j = 0; j < 3; j++) begin
				norm_q[j] <= '0;
			end
			for (int j = 0; j < NCLS; j++) begin
				cnt_q[j] <= '0;
			end
		end else begin
			if (result_valid_q && !result_stall && state_q != ST_FIN) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_valid) begin
						smp_q   <= sample;
						rem_q   <= {sample.red_raw, 8'd0};
						div_q   <= {sample.clear_raw, 12'd0};
						quo_q   <= '0;
						ch_q    <= '0;
						step_q  <= STEP_FIRST;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (step_q == '0) begin
						norm_q[ch_q] <= norm_nxt;
						if (ch_q == 2'd2) begin
							state_q <= ST_FIN;
						end else begin
							ch_q   <= ch_q + 2'd1;
							rem_q  <= {chan_nxt, 8'd0};
							div_q  <= {smp_q.clear_raw, 12'd0};
							quo_q  <= '0;
							step_q <= STEP_FIRST;
						end
					end else begin
						if (ge) begin
							rem_q <= rem_q - div_q[REM_W-1:0];
						end
						quo_q  <= quo_nxt;
						div_q  <= div_q >> 1;
						step_q <= step_q - 4'd1;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						result_q.red_norm     <= norm_q[0];
						result_q.green_norm   <= norm_q[1];
						result_q.blue_norm    <= norm_q[2];
						result_q.sample_class <= cls;
						result_q.vote_valid   <= win_done;
						result_q.vote_class   <= win_done ? vote : CLS_OTHER;
						result_valid_q        <= 1'b1;
						for (int j = 0; j < NCLS; j++) begin
							cnt_q[j] <= win_done ? '0 : cnt_upd[j];
						end
						pos_q   <= win_done ? '0 : pos_inc;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RGBDCV_ASSERT_NXT(a_accept_starts_div, sample_valid && !sample_stall, state_q == ST_DIV && step_q == STEP_FIRST && ch_q == 2'd0, "accepted word did not start the divider")
	`RGBDCV_ASSERT_IMP(a_vote_zero_unless_valid, result_valid && !result.vote_valid, result.vote_class == CLS_OTHER, "vote class set outside window end")
	`RGBDCV_ASSERT_IMP(a_pos_in_window, 1'b1, pos_q < WINDOW, "window position out of range")
	`RGBDCV_ASSERT_IMP(a_counts_match_pos, 1'b1, ({2'b0, cnt_q[0]} + {2'b0, cnt_q[1]} + {2'b0, cnt_q[2]} + {2'b0, cnt_q[3]}) == {2'b0, pos_q}, "class counts disagree with window position")

endmodule

[sim/rgb_dominant_color_vote_tb.sv]
`timescale 1ns / 100ps

module rgb_dominant_color_vote_tb;
	import rgbdcv_pkg::*;

	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned LONG_HOLD  = 300;
	localparam int unsigned DRAIN_WAIT = 60;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	typedef enum logic [1:0] {
		WIN_SINGLE,
		WIN_MIXED,
		WIN_PAIR
	} window_mix_t;

	class color_vote_scoreboard;
		result_t     expected_q[$];
		logic [3:0]  position;
		logic [3:0]  counts[NCLS];
		int unsigned errors;
		int unsigned words_in;
		int unsigned words_out;
		int unsigned votes[NCLS];

		function new();
			position = '0;
			foreach (counts[i]) begin
				counts[i] = '0;
				votes[i] = 0;
			end
			errors = 0;
			words_in = 0;
			words_out = 0;
		endfunction

		function logic [NORM_W-1:0] scale_channel(logic [RAW_W-1:0] chan,
				logic [RAW_W-1:0] clr);
			logic [RAW_W+7:0] q;
			if (clr == '0)
				return NORM_MAX;
			q = {chan, 8'h00} / {8'h00, clr};
			return (q > NORM_MAX) ? NORM_MAX : q[NORM_W-1:0];
		endfunction

		function cls_t classify(logic [NORM_W-1:0] r, logic [NORM_W-1:0] g,
				logic [NORM_W-1:0] b);
			if (r > g && r > b)
				return CLS_RED;
			if (g > r && g > b)
				return CLS_GREEN;
			if (b > r && b > g)
				return CLS_BLUE;
			return CLS_OTHER;
		endfunction

		function void note_sample(sample_t s);
			result_t exp;
			cls_t    winner;
			logic [3:0] best;
			exp.red_norm   = scale_channel(s.red_raw, s.clear_raw);
			exp.green_norm = scale_channel(s.green_raw, s.clear_raw);
			exp.blue_norm  = scale_channel(s.blue_raw, s.clear_raw);
			exp.sample_class = classify(exp.red_norm, exp.green_norm, exp.blue_norm);
			exp.vote_valid = 1'b0;
			exp.vote_class = CLS_OTHER;
			if (counts[exp.sample_class] < CNT_MAX)
				counts[exp.sample_class] = counts[exp.sample_class] + 4'd1;
			position = position + 4'd1;
			if (position >= WINDOW || position == '0) begin
				winner = CLS_OTHER;
				best = '0;
				for (int j = 0; j < NCLS; j++) begin
					if (counts[j] > best) begin
						best = counts[j];
						winner = cls_t'(j);
					end
				end
				exp.vote_valid = 1'b1;
				exp.vote_class = winner;
				votes[winner]++;
				position = '0;
				foreach (counts[i])
					counts[i] = '0;
			end
			expected_q.push_back(exp);
			words_in++;
		endfunction

		function void compare(string field, int unsigned exp, int unsigned act);
			if (exp != act) begin
				$error("%s mismatch: expected %0d, got %0d", field, exp, act);
				errors++;
			end
		endfunction

		function void check_result(result_t r);
			result_t exp;
			if (expected_q.size() == 0) begin
				$error("unexpected result word %h", r);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			words_out++;
			compare("red_norm", exp.red_norm, r.red_norm);
			compare("green_norm", exp.green_norm, r.green_norm);
			compare("blue_norm", exp.blue_norm, r.blue_norm);
			compare("sample_class", exp.sample_class, r.sample_class);
			compare("vote_valid", exp.vote_valid, r.vote_valid);
			compare("vote_class", exp.vote_class, r.vote_class);
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    sample_valid = 1'b0;
	logic    sample_stall;
	sample_t sample = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	color_vote_scoreboard sb;

	int unsigned hold_ticket = 0;
	int unsigned hold_served = 0;
	int unsigned hold_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int unsigned mode_left = 0;
	int unsigned rx_cycle = 0;
	int unsigned idle_cycles = 0;

	window_mix_t win_mix = WIN_SINGLE;
	cls_t        win_cls = CLS_OTHER;
	cls_t        win_alt = CLS_OTHER;
	int unsigned win_left = 0;

	rgb_dominant_color_vote DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// result side: check, then pick next stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_result(result);
		rx_cycle <= rx_cycle + 1;
		if (hold_served != hold_ticket) begin
			hold_served <= hold_ticket;
			hold_left <= LONG_HOLD - 1;
			result_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			result_stall <= 1'b1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= stall_mode_t'($urandom_range(3, 0));
				mode_left <= $urandom_range(256, 64);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE:     result_stall <= 1'b0;
				STALL_LIGHT:    result_stall <= ($urandom_range(3, 0) == 0);
				STALL_HEAVY:    result_stall <= ($urandom_range(3, 0) != 0);
				STALL_PERIODIC: result_stall <= ((rx_cycle % 7) < 3);
				default:        result_stall <= 1'b0;
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
			$display("** rgb_dominant_color_vote: FAILED **");
			$finish;
		end
	end

	task automatic send_sample(input sample_t s);
		sample <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		sb.note_sample(s);
	endtask

	task automatic idle_input(input int unsigned n);
		if (n != 0) begin
			sample_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic sample_t make_sample(cls_t want);
		sample_t     s;
		int unsigned kind;
		int unsigned clr;
		int unsigned dom;
		int unsigned dom_max;
		int unsigned o1;
		int unsigned o2;
		kind = $urandom_range(99, 0);
		if (kind < 8)
			return sample_t'({$urandom(), $urandom()});
		s = sample_t'({$urandom(), $urandom()});
		if (kind < 12) begin
			s.clear_raw = '0;
			return s;
		end
		if (kind < 20) begin
			s.clear_raw = 16'($urandom_range(15, 1));
			return s;
		end
		clr = $urandom_range(65535, 1);
		dom_max = (clr * 15 > 65535) ? 65535 : clr * 15;
		dom = $urandom_range(dom_max, clr / 2 + clr / 256 + 1);
		o1 = $urandom_range(clr / 2, 0);
		o2 = $urandom_range(clr / 2, 0);
		s.clear_raw = 16'(clr);
		if (kind < 26)
			want = CLS_OTHER;
		case (want)
			CLS_RED: begin
				s.red_raw = 16'(dom); s.green_raw = 16'(o1); s.blue_raw = 16'(o2);
			end
			CLS_GREEN: begin
				s.red_raw = 16'(o1); s.green_raw = 16'(dom); s.blue_raw = 16'(o2);
			end
			CLS_BLUE: begin
				s.red_raw = 16'(o1); s.green_raw = 16'(o2); s.blue_raw = 16'(dom);
			end
			default: begin
				// two channels tie at the top
				case ($urandom_range(2, 0))
					0: begin
						s.red_raw = 16'(dom); s.green_raw = 16'(dom); s.blue_raw = 16'(o1);
					end
					1: begin
						s.red_raw = 16'(o1); s.green_raw = 16'(dom); s.blue_raw = 16'(dom);
					end
					default: begin
						s.red_raw = 16'(dom); s.green_raw = 16'(o1); s.blue_raw = 16'(dom);
					end
				endcase
			end
		endcase
		return s;
	endfunction

	// windows lean toward one color, mix freely, or alternate two colors for ties
	function automatic sample_t next_sample();
		cls_t pick;
		if (win_left == 0) begin
			win_mix = window_mix_t'($urandom_range(2, 0));
			win_cls = cls_t'($urandom_range(3, 0));
			win_alt = cls_t'($urandom_range(3, 0));
			win_left = 32'(WINDOW);
		end
		win_left--;
		case (win_mix)
			WIN_SINGLE: pick = ($urandom_range(4, 0) == 0) ? cls_t'($urandom_range(3, 0)) : win_cls;
			WIN_PAIR:   pick = win_left[0] ? win_cls : win_alt;
			default:    pick = cls_t'($urandom_range(3, 0));
		endcase
		return make_sample(pick);
	endfunction

	task automatic run_directed();
		sample_t list[$];
		list.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
		list.push_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
		list.push_back('{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF});
		list.push_back('{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF});
		list.push_back('{16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF});
		list.push_back('{16'hFFFF, 16'h0010, 16'h0000, 16'h0001});
		list.push_back('{16'h000F, 16'h0010, 16'h0000, 16'h0001});
		list.push_back('{16'hFFFF, 16'h0000, 16'h0000, 16'h0000});
		list.push_back('{16'h8000, 16'h8000, 16'h0100, 16'hFFFF});
		list.push_back('{16'h0001, 16'h0000, 16'h0000, 16'hFFFF});
		// five red against five green: tie goes to red
		for (int i = 0; i < 5; i++) begin
			list.push_back('{16'h0100, 16'hF000, 16'h0200, 16'hFFFF});
			list.push_back('{16'h1000, 16'h0800, 16'h0400, 16'h2000});
		end
		for (int i = 0; i < 5; i++)
			list.push_back('{16'h0001, 16'h0002, 16'hFFFE, 16'hFFFF});
		foreach (list[i])
			send_sample(list[i]);
	endtask

	task automatic run_random(input int unsigned total);
		int unsigned sent;
		int unsigned burst;
		sent = 0;
		while (sent < total) begin
			burst = $urandom_range(40, 1);
			for (int i = 0; i < burst && sent < total; i++) begin
				send_sample(next_sample());
				sent++;
			end
			idle_input(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(30, 1));
		end
	endtask

	initial begin
		sb = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		wait_drained();
		run_random(600);
		// receiver holds off while words keep coming, so the input backs up
		hold_ticket <= hold_ticket + 1;
		for (int i = 0; i < 40; i++)
			send_sample(next_sample());
		run_random(500);
		wait_drained();
		run_random(500);
		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		$display("ran %0d sample words, checked %0d result words", sb.words_in, sb.words_out);
		$display("window votes other/red/green/blue: %0d/%0d/%0d/%0d",
			sb.votes[CLS_OTHER], sb.votes[CLS_RED], sb.votes[CLS_GREEN], sb.votes[CLS_BLUE]);
		if (sb.pending() != 0) begin
			$error("%0d result words never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("** rgb_dominant_color_vote: PASSED **");
		else
			$display("** rgb_dominant_color_vote: FAILED **");
		$finish;
	end

endmodule
